// ===== src/cplp_pkg.sv =====
package cplp_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned NumCoef     = 24;
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned DivSteps    = 31;

  // stage numbers; the value after stage k sits in register k
  localparam int unsigned StgSqrt0 = 14;
  localparam int unsigned StgDiv0  = StgSqrt0 + SqrtSteps;
  localparam int unsigned StgOut   = StgDiv0 + DivSteps;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_NORM = 2'd1,
    ST_LINE_INF  = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0][31:0]  pt;
    logic [31:0]       u;
    logic [31:0]       v;
    logic [23:0][63:0] prd;
    logic [2:0][31:0]  pa;
    logic [2:0][31:0]  pb;
    logic [2:0][31:0]  ln;
    logic [63:0]       s;
    logic [63:0]       t;
    logic [63:0]       nn;
    logic [63:0]       m0;
    logic [63:0]       m1;
    logic              neg0;
    logic              neg1;
    logic              sgn_s;
    logic              sgn_t;
    logic              sat0;
    logic              sat1;
    status_e           status;
    logic [5:0]        lz;
    logic [29:0]       msn;
    logic [29:0]       mtn;
    logic [63:0]       sqx;
    logic [63:0]       root;
    logic [63:0]       rr0;
    logic [63:0]       rr1;
    logic [63:0]       rs;
    logic [63:0]       rt;
    logic [30:0]       lo0;
    logic [30:0]       lo1;
    logic [30:0]       los;
    logic [30:0]       lot;
    logic [30:0]       q0;
    logic [30:0]       q1;
    logic [30:0]       qs;
    logic [30:0]       qt;
    logic [31:0]       dir_s;
    logic [31:0]       dir_t;
    logic [31:0]       res_x;
    logic [31:0]       res_y;
  } pipe_t;

  // one restoring division step: returns {rem, low bits, quotient}
  function automatic logic [125:0] div_step(logic [63:0] rem, logic [30:0] lo,
                                            logic [30:0] q, logic [63:0] dv);
    logic [64:0] r2;
    logic [63:0] rn;
    logic [30:0] qn;
    r2 = {rem, lo[30]};
    if (r2 >= {1'b0, dv}) begin
      rn = 64'(r2 - {1'b0, dv});
      qn = {q[29:0], 1'b1};
    end else begin
      rn = r2[63:0];
      qn = {q[29:0], 1'b0};
    end
    return {rn, {lo[29:0], 1'b0}, qn};
  endfunction

endpackage

// ===== src/camera_pencil_line_params_unit.sv =====
// Two-camera pencil evaluator. Load transfers (req_type_i = 0) write one of the 24
// camera coefficients and give no result; evaluate transfers project the world point
// through both cameras, shift by (u,v), form the joining line and return the
// normalised weights, the two residuals and a status. One transfer is taken every
// cycle unless stall_o is high; an evaluate result reaches the output register after
// the 13 projection and line stages, the 32 square-root stages and the 31 divider
// stages. A load affects every evaluate taken after it. The whole pipeline advances
// together and holds while a finished result is stalled.
module camera_pencil_line_params_unit import cplp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        req_type_i,
  input  logic [4:0]  coef_index_i,
  input  logic [31:0] coef_value_i,
  input  logic [31:0] pt_x_i,
  input  logic [31:0] pt_y_i,
  input  logic [31:0] pt_z_i,
  input  logic [31:0] pt_w_i,
  input  logic [31:0] img_u_i,
  input  logic [31:0] img_v_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] dir_s_o,
  output logic [31:0] dir_t_o,
  output logic [31:0] resid_x_o,
  output logic [31:0] resid_y_o,
  output logic [1:0]  status_o
);

  localparam int unsigned DW    = 64 + FRAC_BITS;
  localparam int unsigned SatSh = 31 - FRAC_BITS;

  function automatic logic [63:0] sx(logic [31:0] a);
    return {{32{a[31]}}, a};
  endfunction

  function automatic logic [63:0] mulf(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    return 64'(p);
  endfunction

  function automatic logic [63:0] mulsh(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(mulf(a, b));
    return 64'(p >>> FRAC_BITS);
  endfunction

  function automatic logic [31:0] sat32(logic [63:0] x);
    logic [31:0] r;
    if ($signed(x) > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if ($signed(x) < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] x);
    return x[63] ? 64'(-x) : x;
  endfunction

  logic                    adv;
  logic                    accept;
  logic [NumCoef-1:0][31:0] coef_q;
  logic [StgOut:0]         vld_q;
  logic [StgOut:0]         vld_d;
  pipe_t                   pipe_q [StgOut+1];
  pipe_t                   pipe_d [StgOut+1];

  assign adv     = !vld_q[StgOut] || !stall_i;
  assign stall_o = !adv;
  assign accept  = valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (accept && req_type_i == REQ_LOAD && coef_index_i < 5'(NumCoef)) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  always_comb begin
    vld_d    = {vld_q[StgOut-1:0], valid_i && req_type_i == REQ_EVAL};
    pipe_d[0]       = '0;
    pipe_d[0].pt[0] = pt_x_i;
    pipe_d[0].pt[1] = pt_y_i;
    pipe_d[0].pt[2] = pt_z_i;
    pipe_d[0].pt[3] = pt_w_i;
    pipe_d[0].u     = img_u_i;
    pipe_d[0].v     = img_v_i;
  end

  for (genvar k = 1; k <= StgOut; k++) begin : g_stg
    always_comb begin : p_stage
      pipe_t       d;
      logic [63:0] acc;
      logic [63:0] bitv;
      logic [63:0] tmp;
      logic [63:0] w;
      logic [5:0]  z;
      logic [DW-1:0] dres;
      logic [94:0] lhs;
      logic [94:0] rhs;
      logic [125:0] ds;
      int unsigned j;
      acc  = '0;
      bitv = '0;
      tmp  = '0;
      w    = '0;
      z    = '0;
      dres = '0;
      lhs  = '0;
      rhs  = '0;
      ds   = '0;
      j    = 0;
      d    = pipe_q[k-1];
      if (k == 1) begin
        for (int i = 0; i < NumCoef; i++) begin
          d.prd[i] = mulsh(coef_q[i], d.pt[i % 4]);
        end
      end else if (k == 2) begin
        for (int r = 0; r < 3; r++) begin
          acc = d.prd[r*4] + d.prd[r*4+1] + d.prd[r*4+2] + d.prd[r*4+3];
          d.pa[r] = sat32(acc);
          acc = d.prd[12+r*4] + d.prd[12+r*4+1] + d.prd[12+r*4+2] + d.prd[12+r*4+3];
          d.pb[r] = sat32(acc);
        end
      end else if (k == 3) begin
        d.prd[0] = mulsh(d.u, d.pa[2]);
        d.prd[1] = mulsh(d.v, d.pa[2]);
        d.prd[2] = mulsh(d.u, d.pb[2]);
        d.prd[3] = mulsh(d.v, d.pb[2]);
      end else if (k == 4) begin
        d.pa[0] = sat32(sx(d.pa[0]) - d.prd[0]);
        d.pa[1] = sat32(sx(d.pa[1]) - d.prd[1]);
        d.pb[0] = sat32(sx(d.pb[0]) - d.prd[2]);
        d.pb[1] = sat32(sx(d.pb[1]) - d.prd[3]);
      end else if (k == 5) begin
        d.prd[0] = mulsh(d.pa[1], d.pb[2]);
        d.prd[1] = mulsh(d.pa[2], d.pb[1]);
        d.prd[2] = mulsh(d.pa[2], d.pb[0]);
        d.prd[3] = mulsh(d.pa[0], d.pb[2]);
        d.prd[4] = mulsh(d.pa[0], d.pb[1]);
        d.prd[5] = mulsh(d.pa[1], d.pb[0]);
      end else if (k == 6) begin
        d.ln[0] = sat32(d.prd[0] - d.prd[1]);
        d.ln[1] = sat32(d.prd[2] - d.prd[3]);
        d.ln[2] = sat32(d.prd[4] - d.prd[5]);
      end else if (k == 7) begin
        d.prd[0] = mulsh(d.ln[1], d.pb[0]);
        d.prd[1] = mulsh(d.ln[0], d.pb[1]);
        d.prd[2] = mulsh(d.ln[0], d.pa[1]);
        d.prd[3] = mulsh(d.ln[1], d.pa[0]);
        d.prd[4] = mulf(d.ln[0], d.ln[0]);
        d.prd[5] = mulf(d.ln[1], d.ln[1]);
        d.prd[6] = mulf(d.ln[0], d.ln[2]);
        d.prd[7] = mulf(d.ln[1], d.ln[2]);
      end else if (k == 8) begin
        d.s    = d.prd[0] - d.prd[1];
        d.t    = d.prd[2] - d.prd[3];
        d.nn   = d.prd[4] + d.prd[5];
        d.m0   = mag64(d.prd[6]);
        d.m1   = mag64(d.prd[7]);
        d.neg0 = d.prd[6][63];
        d.neg1 = d.prd[7][63];
      end else if (k == 9) begin
        d.sgn_s = d.s[63];
        d.sgn_t = d.t[63];
        d.s     = mag64(d.s);
        d.t     = mag64(d.t);
        d.sqx   = (d.s > d.t) ? d.s : d.t;
        if (d.sqx == '0) begin
          d.status = ST_ZERO_NORM;
        end else if (d.nn == '0) begin
          d.status = ST_LINE_INF;
        end else begin
          d.status = ST_OK;
        end
        // quotient of 2^31 or more saturates
        rhs    = 95'(d.nn) << SatSh;
        lhs    = 95'(d.m0);
        d.sat0 = lhs >= rhs;
        lhs    = 95'(d.m1);
        d.sat1 = lhs >= rhs;
        dres   = {d.m0, {FRAC_BITS{1'b0}}};
        tmp    = 64'(dres >> 31);
        d.rr0  = tmp;
        d.lo0  = dres[30:0];
        dres   = {d.m1, {FRAC_BITS{1'b0}}};
        tmp    = 64'(dres >> 31);
        d.rr1  = tmp;
        d.lo1  = dres[30:0];
        d.q0   = '0;
        d.q1   = '0;
      end else if (k == 10) begin
        // leading-zero count by halving search
        w = d.sqx;
        z = '0;
        for (int sz = 32; sz >= 1; sz = sz / 2) begin
          if ((w >> (64 - sz)) == '0) begin
            w = w << sz;
            z = z + 6'(sz);
          end
        end
        d.lz = z;
      end else if (k == 11) begin
        tmp   = d.s << d.lz;
        d.msn = tmp[63:34];
        tmp   = d.t << d.lz;
        d.mtn = tmp[63:34];
      end else if (k == 12) begin
        d.prd[0] = 64'(d.msn) * 64'(d.msn);
        d.prd[1] = 64'(d.mtn) * 64'(d.mtn);
      end else if (k == 13) begin
        d.sqx  = d.prd[0] + d.prd[1];
        d.root = '0;
        d.rs   = 64'(d.msn >> 1);
        d.los  = {d.msn[0], 30'b0};
        d.rt   = 64'(d.mtn >> 1);
        d.lot  = {d.mtn[0], 30'b0};
        d.qs   = '0;
        d.qt   = '0;
      end else if (k < StgDiv0) begin
        j    = k - StgSqrt0;
        bitv = 64'(1) << (62 - 2 * j);
        tmp  = d.root + bitv;
        if (d.sqx >= tmp) begin
          d.sqx  = d.sqx - tmp;
          d.root = (d.root >> 1) + bitv;
        end else begin
          d.root = d.root >> 1;
        end
        if (k < StgSqrt0 + DivSteps) begin
          ds    = div_step(d.rr0, d.lo0, d.q0, d.nn);
          d.rr0 = ds[125:62];
          d.lo0 = ds[61:31];
          d.q0  = ds[30:0];
          ds    = div_step(d.rr1, d.lo1, d.q1, d.nn);
          d.rr1 = ds[125:62];
          d.lo1 = ds[61:31];
          d.q1  = ds[30:0];
        end
      end else if (k < StgOut) begin
        ds   = div_step(d.rs, d.los, d.qs, d.root);
        d.rs  = ds[125:62];
        d.los = ds[61:31];
        d.qs  = ds[30:0];
        ds   = div_step(d.rt, d.lot, d.qt, d.root);
        d.rt  = ds[125:62];
        d.lot = ds[61:31];
        d.qt  = ds[30:0];
      end else begin
        if (d.status != ST_OK) begin
          d.dir_s = '0;
          d.dir_t = '0;
          d.res_x = '0;
          d.res_y = '0;
        end else begin
          d.dir_s = d.sgn_s ? 32'(-{1'b0, d.qs}) : {1'b0, d.qs};
          d.dir_t = d.sgn_t ? 32'(-{1'b0, d.qt}) : {1'b0, d.qt};
          if (d.sat0) begin
            d.res_x = d.neg0 ? 32'h8000_0000 : 32'h7fff_ffff;
          end else begin
            d.res_x = d.neg0 ? 32'(-{1'b0, d.q0}) : {1'b0, d.q0};
          end
          if (d.sat1) begin
            d.res_y = d.neg1 ? 32'h8000_0000 : 32'h7fff_ffff;
          end else begin
            d.res_y = d.neg1 ? 32'(-{1'b0, d.q1}) : {1'b0, d.q1};
          end
        end
      end
      // drop fields no later stage reads
      if (k >= 2) begin
        d.pt = '0;
      end
      if (k >= 5) begin
        d.u = '0;
        d.v = '0;
      end
      if (k >= 8) begin
        d.pa = '0;
        d.pb = '0;
        d.ln = '0;
      end
      if (k >= 13) begin
        d.prd = '0;
        d.s   = '0;
        d.t   = '0;
      end
      if (k >= 10) begin
        d.m0 = '0;
        d.m1 = '0;
      end
      if (k >= StgSqrt0) begin
        d.msn = '0;
        d.mtn = '0;
        d.lz  = '0;
      end
      if (k >= StgSqrt0 + DivSteps) begin
        d.nn  = '0;
        d.rr0 = '0;
        d.rr1 = '0;
        d.lo0 = '0;
        d.lo1 = '0;
      end
      if (k >= StgDiv0) begin
        d.sqx = '0;
      end
      pipe_d[k] = d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= StgOut; i++) begin
        pipe_q[i] <= pipe_d[i];
      end
    end
  end

  assign valid_o   = vld_q[StgOut];
  assign dir_s_o   = pipe_q[StgOut].dir_s;
  assign dir_t_o   = pipe_q[StgOut].dir_t;
  assign resid_x_o = pipe_q[StgOut].res_x;
  assign resid_y_o = pipe_q[StgOut].res_y;
  assign status_o  = pipe_q[StgOut].status;

  // a failed status carries no numeric result
  a_bad_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != ST_OK |->
      dir_s_o == '0 && dir_t_o == '0 && resid_x_o == '0 && resid_y_o == '0)
    else $error("nonzero result with failed status");

  // each weight stays within +/-2^30, that is within +/-1.0
  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == ST_OK |->
      $signed(dir_s_o) <= 32'sd1073741824 && $signed(dir_s_o) >= -32'sd1073741824 &&
      $signed(dir_t_o) <= 32'sd1073741824 && $signed(dir_t_o) >= -32'sd1073741824)
    else $error("weight out of range");

  // while held, the valid bits of the pipeline stay unchanged
  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

endmodule
